FILE: design/cti_pkg.sv
// ----------------------------------------------------------------------------
// Calibration table interpolator package
// Shared types and constants for the interpolator front end and back end.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = 7;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [5:0]  entry_index;
    logic [31:0] entry_freq;
    logic signed [31:0] entry_value_a;
    logic signed [31:0] entry_value_b;
    logic [31:0] query_freq;
  } cti_in_t;

  typedef struct packed {
    logic        found;
    logic signed [31:0] interp_a;
    logic signed [31:0] interp_b;
  } cti_out_t;

  // One queued query: the frequency and the clamped entry count.
  typedef struct packed {
    logic [31:0]     freq;
    logic [CntW-1:0] count;
  } cti_query_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } cti_state_e;

endpackage

FILE: design/cti_queue.sv
// ----------------------------------------------------------------------------
// Query queue
// Short FIFO that carries classified queries from the front end to the back.
// ----------------------------------------------------------------------------
module cti_queue
  import cti_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cti_query_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output cti_query_t pop_data_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cti_query_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;

  assign full_o     = (fill_q == (PtrW+1)'(QueueDepth));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

FILE: design/cti_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cti_divider
  import cti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;

  assign done_o = done_q;
  assign quot_o = quot_q;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[63]} - {2'b00, dsr_q};
      if (!trial[33]) begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[63]};
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

FILE: design/cti_back.sv
// ----------------------------------------------------------------------------
// Interpolation back end
// Scans the point table for the bracketing segment and interpolates.
// ----------------------------------------------------------------------------
module cti_back
  import cti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [95:0]     wr_data_i,
  input  logic            q_empty_i,
  input  cti_query_t      q_data_i,
  output logic            q_pop_o,
  output logic            idle_o,
  output logic            valid_o,
  output cti_out_t        result_o
);

  // Entry layout: freq, value a, value b.
  logic [95:0] mem_q [TableDepth];
  logic [95:0] rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic        rd_en;

  cti_state_e  state_q, state_d;
  cti_query_t  cur_q, cur_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [95:0] prev_q, prev_d;
  logic        have_prev_q, have_prev_d;
  logic [31:0] t_q, t_d, d_q, d_d;
  logic signed [31:0] y0a_q, y0a_d, y0b_q, y0b_d;
  logic        nega_q, nega_d, negb_q, negb_d;
  logic [32:0] maga_q, maga_d, magb_q, magb_d;
  logic [63:0] proda_q, proda_d, prodb_q, prodb_d;
  logic        div_sel_q, div_sel_d;
  logic [63:0] qa_q, qa_d;
  logic        div_start, div_done;
  logic [63:0] div_quot;
  logic        valid_d;
  cti_out_t    res_q, res_d;
  logic        valid_q;

  logic [31:0] f0, f1;
  logic signed [32:0] dya, dyb;

  function automatic logic signed [31:0] sat_apply(input logic signed [31:0] y0,
                                                   input logic neg,
                                                   input logic [63:0] q);
    logic signed [65:0] r;
    r = neg ? (66'(y0) - $signed({2'b00, q})) : (66'(y0) + $signed({2'b00, q}));
    if (r > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // The operand select follows the next-state value so that the second
  // division latches the b product in the cycle that launches it.
  cti_divider u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_sel_d ? prodb_q : proda_q),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign f0  = prev_q[95:64];
  assign f1  = rd_data_q[95:64];
  assign dya = 33'(signed'(rd_data_q[63:32])) - 33'(signed'(prev_q[63:32]));
  assign dyb = 33'(signed'(rd_data_q[31:0])) - 33'(signed'(prev_q[31:0]));

  assign idle_o   = (state_q == ST_IDLE) && q_empty_i;
  assign valid_o  = valid_q;
  assign result_o = res_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    t_d = t_q;  d_d = d_q;
    y0a_d = y0a_q;  y0b_d = y0b_q;
    nega_d = nega_q;  negb_d = negb_q;
    maga_d = maga_q;  magb_d = magb_q;
    proda_d = proda_q;  prodb_d = prodb_q;
    div_sel_d = div_sel_q;
    qa_d      = qa_q;
    div_start = 1'b0;
    q_pop_o   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_q[IdxW-1:0];
    valid_d   = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o     = 1'b1;
          cur_d       = q_data_i;
          idx_d       = '0;
          have_prev_d = 1'b0;
          if (q_data_i.count < CntW'(2)) begin
            state_d = ST_DONE;
            res_d   = '0;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (have_prev_q && cur_q.freq >= f0 && cur_q.freq < f1) begin
          t_d    = cur_q.freq - f0;
          d_d    = f1 - f0;
          y0a_d  = prev_q[63:32];
          y0b_d  = prev_q[31:0];
          nega_d = dya[32];
          negb_d = dyb[32];
          maga_d = dya[32] ? 33'(-dya) : 33'(dya);
          magb_d = dyb[32] ? 33'(-dyb) : 33'(dyb);
          state_d = ST_MUL;
        end else if (idx_q + 1'b1 >= cur_q.count) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          prev_d      = rd_data_q;
          have_prev_d = 1'b1;
          idx_d       = idx_q + 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_MUL: begin
        proda_d   = 64'(maga_q) * 64'(t_q);
        prodb_d   = 64'(magb_q) * 64'(t_q);
        div_sel_d = 1'b0;
        state_d   = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (!div_sel_q) begin
            qa_d      = div_quot;
            div_sel_d = 1'b1;
            div_start = 1'b1;
          end else begin
            res_d.found    = 1'b1;
            res_d.interp_a = sat_apply(y0a_q, nega_q, qa_q);
            res_d.interp_b = sat_apply(y0b_q, negb_q, div_quot);
            state_d        = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;  prev_q <= prev_d;
    t_q <= t_d;  d_q <= d_d;
    y0a_q <= y0a_d;  y0b_q <= y0b_d;
    nega_q <= nega_d;  negb_q <= negb_d;
    maga_q <= maga_d;  magb_q <= magb_d;
    proda_q <= proda_d;  prodb_q <= prodb_d;
    qa_q <= qa_d;  res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      have_prev_q <= 1'b0;
      div_sel_q   <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      have_prev_q <= have_prev_d;
      div_sel_q   <= div_sel_d;
      valid_q     <= valid_d;
    end
  end

endmodule

FILE: design/cti_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts items, writes load items into the table and queues queries.
// ----------------------------------------------------------------------------
module cti_front
  import cti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  cti_in_t         item_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            q_full_i,
  input  logic            idle_i,
  output logic            busy,
  output logic            q_push_o,
  output cti_query_t      q_data_o,
  output logic            wr_en_o,
  output logic [IdxW-1:0] wr_idx_o,
  output logic [95:0]     wr_data_o
);

  logic [CntW-1:0] count_q;
  logic            accept;

  // A load waits until every earlier query has finished with the table.
  assign busy     = q_full_i || ((item_i.func == FUNC_LOAD) && !idle_i);
  assign accept   = start && !busy;
  assign wr_en_o  = accept && (item_i.func == FUNC_LOAD);
  assign wr_idx_o = item_i.entry_index[IdxW-1:0];
  assign wr_data_o = {item_i.entry_freq, item_i.entry_value_a, item_i.entry_value_b};
  assign q_push_o = accept && (item_i.func == FUNC_QUERY);
  assign q_data_o.freq  = item_i.query_freq;
  assign q_data_o.count = (count_q > CntW'(TableDepth)) ? CntW'(TableDepth) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: design/calibration_table_interpolator.sv
// ----------------------------------------------------------------------------
// Calibration table interpolator
// Piecewise linear interpolation over a 64-point calibration table.
// ----------------------------------------------------------------------------
// A load writes the table directly and gives no result, but it is held off
// with busy while any query is queued or in progress, so it never changes the
// table under an earlier query. A query scans the table one entry at a time,
// reading then comparing each (one memory read port), then multiplies and runs
// two divisions one after the other on a shared serial divider. Up to two
// queries wait in a queue; busy is high for any item while it is full. Results
// arrive on strobe_o and cannot be stalled.
module calibration_table_interpolator
  import cti_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cti_in_t  item_i,
  input  logic     cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  output logic     strobe_o,
  output cti_out_t result_o
);

  logic            q_push, q_pop, q_full, q_empty, wr_en, idle;
  cti_query_t      q_in, q_out;
  logic [IdxW-1:0] wr_idx;
  logic [95:0]     wr_data;

  cti_front u_front (
    .clk_i, .rst_ni, .start, .item_i, .cfg_we_i, .cfg_wdata_i,
    .q_full_i(q_full), .idle_i(idle), .busy, .q_push_o(q_push), .q_data_o(q_in),
    .wr_en_o(wr_en), .wr_idx_o(wr_idx), .wr_data_o(wr_data)
  );

  cti_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .push_data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .pop_data_o(q_out), .empty_o(q_empty)
  );

  cti_back u_back (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_data_i(wr_data),
    .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop), .idle_o(idle),
    .valid_o(strobe_o), .result_o
  );

endmodule

FILE: dv/tb_calibration_table_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calibration table interpolator testbench
// Loads point tables into the block and queries interpolated values at many
// frequencies under several entry counts. A local model of the table predicts
// every query result; each strobed result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_calibration_table_interpolator;
  import cti_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  cti_in_t         item_i = '0;
  logic            cfg_we_i = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            strobe_o;
  cti_out_t        result_o;

  calibration_table_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .strobe_o   (strobe_o),
    .result_o   (result_o)
  );

  always #5 clk_i = ~clk_i;

  localparam int WatchLimit = 8000;

  // Local copy of the point table and the entry count.
  logic [31:0]        pt_freq [TableDepth];
  logic signed [31:0] pt_a    [TableDepth];
  logic signed [31:0] pt_b    [TableDepth];
  logic [CntW-1:0]    count_q;

  cti_out_t pending_results[$];
  int       errors = 0;
  int       n_loads = 0;
  int       n_queries = 0;
  int       n_found = 0;
  int       idle_cycles = 0;
  bit       idle_en = 1'b1;

  function automatic logic signed [31:0] lerp_value(logic signed [31:0] y0,
                                                    logic signed [31:0] y1,
                                                    logic [31:0] t, logic [31:0] d);
    longint            dy;
    longint unsigned   mag;
    longint unsigned   q;
    longint            r;
    dy  = longint'(y1) - longint'(y0);
    mag = (dy < 0) ? longint'(-dy) : dy;
    q   = (mag * {32'd0, t}) / {32'd0, d};
    r   = (dy < 0) ? longint'(y0) - longint'(q) : longint'(y0) + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic cti_out_t interpolate(logic [31:0] f);
    cti_out_t res;
    int       n;
    res = '0;
    n = (count_q > TableDepth) ? TableDepth : count_q;
    for (int i = 0; i + 1 < n; i++) begin
      if (f >= pt_freq[i] && f < pt_freq[i+1]) begin
        res.found    = 1'b1;
        res.interp_a = lerp_value(pt_a[i], pt_a[i+1], f - pt_freq[i],
                                  pt_freq[i+1] - pt_freq[i]);
        res.interp_b = lerp_value(pt_b[i], pt_b[i+1], f - pt_freq[i],
                                  pt_freq[i+1] - pt_freq[i]);
        break;
      end
    end
    return res;
  endfunction

  // Sends one item and updates the local table or queues the expected result.
  task automatic send_item(cti_in_t it);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99, 0) < 9) begin
      start = 1'b0;
      idle_cycles++;
      @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
    if (func_e'(it.func) == FUNC_LOAD) begin
      pt_freq[it.entry_index] = it.entry_freq;
      pt_a[it.entry_index]    = it.entry_value_a;
      pt_b[it.entry_index]    = it.entry_value_b;
      n_loads++;
    end else begin
      pending_results.push_back(interpolate(it.query_freq));
      n_queries++;
    end
  endtask

  task automatic load_point(int idx, logic [31:0] f, logic [31:0] a, logic [31:0] b);
    cti_in_t it;
    it = '0;
    it.func          = FUNC_LOAD;
    it.entry_index   = idx[5:0];
    it.entry_freq    = f;
    it.entry_value_a = a;
    it.entry_value_b = b;
    it.query_freq    = $urandom;
    send_item(it);
  endtask

  task automatic query_at(logic [31:0] f);
    cti_in_t it;
    it = '0;
    it.func          = FUNC_QUERY;
    it.entry_index   = $urandom;
    it.entry_freq    = $urandom;
    it.entry_value_a = $urandom;
    it.entry_value_b = $urandom;
    it.query_freq    = f;
    send_item(it);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain;
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_count(logic [CntW-1:0] v);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    count_q     = v;
  endtask

  // Fills all slots with ascending frequencies; zero steps give repeated points.
  task automatic load_sorted_table(int max_step);
    logic [31:0] f;
    f = $urandom_range(1 << 20, 0);
    for (int i = 0; i < TableDepth; i++) begin
      load_point(i, f, $urandom, $urandom);
      if ($urandom_range(9, 0) != 0) f = f + $urandom_range(max_step, 1);
    end
  endtask

  task automatic query_in_segment(int n);
    int          k;
    logic [31:0] d;
    k = $urandom_range(n - 2, 0);
    d = pt_freq[k+1] - pt_freq[k];
    if (pt_freq[k+1] > pt_freq[k]) query_at(pt_freq[k] + ($urandom % d));
    else query_at(pt_freq[k]);
  endtask

  task automatic test_fill_table;
    load_sorted_table(1 << 25);
  endtask

  task automatic test_directed;
    set_count(0);
    query_at(pt_freq[0]);
    set_count(1);
    query_at(pt_freq[0]);
    set_count(64);
    query_at(pt_freq[0]);
    query_at(pt_freq[63]);
    query_at(32'hFFFF_FFFF);
    query_at(32'h0000_0000);
    query_at(pt_freq[1] - 1);
    // Widest segment: full-scale swings in both directions across the whole range.
    load_point(0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    load_point(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    query_at(32'hFFFF_FFFE);
    query_at(32'h8000_0000);
    query_at(32'h0000_0001);
    query_at(32'hFFFF_FFFF);
    load_point(63, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    set_count(2);
    query_at(32'h7FFF_FFFF);
    set_count(127);
    query_at(32'h1234_5678);
    set_count(65);
    query_at(32'hFFFF_FFFE);
    test_fill_table();
  endtask

  task automatic test_random_phase(logic [CntW-1:0] cnt, int items, bit noisy);
    int n;
    set_count(cnt);
    n = (cnt > TableDepth) ? TableDepth : cnt;
    for (int j = 0; j < items; j++) begin
      if ($urandom_range(9, 0) < 3) begin
        int idx;
        idx = $urandom_range(TableDepth - 1, 0);
        if (noisy || $urandom_range(4, 0) == 0 || idx == 0 || idx == TableDepth - 1) begin
          load_point(idx, $urandom, $urandom, $urandom);
        end else if (pt_freq[idx+1] >= pt_freq[idx-1]) begin
          logic [31:0] span;
          span = pt_freq[idx+1] - pt_freq[idx-1];
          load_point(idx, pt_freq[idx-1] + ((span == 32'hFFFF_FFFF) ? $urandom
                     : ($urandom % (span + 1))), $urandom, $urandom);
        end else begin
          load_point(idx, $urandom, $urandom, $urandom);
        end
      end else if (n >= 2 && $urandom_range(9, 0) < 8) begin
        query_in_segment(n);
      end else begin
        query_at($urandom);
      end
    end
  endtask

  task automatic test_no_idle;
    idle_en = 1'b0;
    test_random_phase(64, 200, 1'b0);
    idle_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", result_o);
      end else begin
        cti_out_t exp_r;
        exp_r = pending_results.pop_front();
        if (result_o.found !== exp_r.found || result_o.interp_a !== exp_r.interp_a ||
            result_o.interp_b !== exp_r.interp_b) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected found=%0b a=%0d b=%0d, got found=%0b a=%0d b=%0d",
                     exp_r.found, exp_r.interp_a, exp_r.interp_b,
                     result_o.found, result_o.interp_a, result_o.interp_b);
        end else if (exp_r.found) begin
          n_found++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      pt_freq[i] = '0;
      pt_a[i]    = '0;
      pt_b[i]    = '0;
    end
    count_q = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_fill_table();
    test_directed();
    test_random_phase(64, 300, 1'b0);
    test_random_phase($urandom_range(63, 3), 250, 1'b0);
    test_no_idle();
    test_random_phase(2, 120, 1'b0);
    test_random_phase(100, 200, 1'b0);
    test_random_phase(64, 200, 1'b1);
    load_sorted_table(1 << 20);
    test_random_phase($urandom_range(64, 2), 250, 1'b0);
    test_random_phase(1, 60, 1'b0);
    test_random_phase(64, 150, 1'b0);
    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d loads and %0d queries, %0d of them inside a segment",
             n_loads, n_queries, n_found);
    $display("entry counts 0 through 127 including clamped ones, %0d sender idle cycles",
             idle_cycles);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/cti_pkg.sv
design/cti_queue.sv
design/cti_divider.sv
design/cti_back.sv
design/cti_front.sv
design/calibration_table_interpolator.sv
dv/tb_calibration_table_interpolator.sv
